/* sv/ste_pkg.sv */
// Shared constants, types and arithmetic helpers for the stereo tape echo.
package ste_pkg;

  localparam int unsigned DelayFramesDefault = 65536;
  localparam int unsigned SineQuarterDefault = 256;

  localparam int unsigned SampleW = 24;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned CfgIdxW = 3;

  // Register reset values
  localparam logic [23:0] BaseDelayReset    = 24'd1016064;
  localparam logic [12:0] ModDepthReset     = 13'd4608;
  localparam logic [30:0] WowStepReset      = 31'd17531;
  localparam logic [30:0] FlutterStepReset  = 31'd360350;
  localparam logic [15:0] FeedbackReset     = 16'd0;
  localparam logic [16:0] WetReset          = 17'd0;
  localparam logic [16:0] SmoothReset       = 17'd18350;

  // Flutter depth is 0.35 of wow depth, Q16
  localparam logic [14:0] FlutterRatio = 15'd22938;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_DELAY   = 3'd0,
    CFG_MOD_DEPTH    = 3'd1,
    CFG_WOW_STEP     = 3'd2,
    CFG_FLUTTER_STEP = 3'd3,
    CFG_FEEDBACK     = 3'd4,
    CFG_WET          = 3'd5,
    CFG_SMOOTH       = 3'd6
  } cfg_idx_e;

  // Clamp to the signed 24 bit range
  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) r = 24'sh7FFFFF;
    else if (v < -32'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // Sine of a Q30 angle as Q15, Taylor series to x^11; used at elaboration only
  function automatic logic [14:0] sine_q15(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x2 = (x * x) >> 30;
    t = (64'd1 << 30) - x2 / 110;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return s[14:0];
  endfunction

endpackage

/* sv/stereo_tape_echo.sv */
// Stereo tape echo: modulated delay line with lowpass feedback, one frame per item.
//
//  channel | dir | handshake             | payload (lowest bits first)
//  s_axis  | in  | tvalid/tready         | tdata: in_left[23:0], in_right[47:24]
//  m_axis  | out | tvalid/tready         | tdata: out_left[23:0], out_right[47:24]
//  cfg     | in  | cfg_we_i, no wait     | cfg_idx_i selects, cfg_wdata_i carries value
//
// A new item is taken only in ST_IDLE, once the last is written back; the sequencer
// makes two reads and one write of the delay memory per item through one port.
// Reset clears all control state; the delay memory is not cleared, a fill count
// makes entries not yet written read as zero, so no clearing pass is needed.
// A result waiting on m_axis holds the sequencer before the lowpass update only.
module stereo_tape_echo #(
  parameter int unsigned DELAY_FRAMES = ste_pkg::DelayFramesDefault,
  parameter int unsigned SINE_QUARTER_ENTRIES = ste_pkg::SineQuarterDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,   // in_left, in_right
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,   // out_left, out_right
  input  logic                        cfg_we_i,
  input  logic [ste_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ste_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(DELAY_FRAMES);
  localparam int unsigned FLOG = $clog2(DELAY_FRAMES + 1) - 1;
  localparam int unsigned MAG_W = (AW + 23 > 40) ? AW + 23 : 40;
  localparam int unsigned STEPS_RAW = MAG_W - 23 - FLOG;
  localparam int unsigned REDUCE_STEPS = (STEPS_RAW > 0) ? STEPS_RAW : 1;
  localparam int unsigned SW = (REDUCE_STEPS > 1) ? $clog2(REDUCE_STEPS) : 1;
  localparam int unsigned SQ = SINE_QUARTER_ENTRIES;
  localparam int unsigned SQW = $clog2(SQ + 1);
  localparam logic [MAG_W:0] SPAN = (MAG_W + 1)'(DELAY_FRAMES) << 23;

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_WOW  = 14'b00000000000010,
    ST_FLUT = 14'b00000000000100,
    ST_MOD  = 14'b00000000001000,
    ST_SUB  = 14'b00000000010000,
    ST_RED  = 14'b00000000100000,
    ST_FIX  = 14'b00000001000000,
    ST_RD0  = 14'b00000010000000,
    ST_RD1  = 14'b00000100000000,
    ST_RD2  = 14'b00001000000000,
    ST_INT  = 14'b00010000000000,
    ST_LP1  = 14'b00100000000000,
    ST_LP2  = 14'b01000000000000,
    ST_FB   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [23:0] base_q;
  logic [12:0] depth_q;
  logic [30:0] wow_step_q, flut_step_q;
  logic [15:0] fb_q;
  logic [16:0] wet_q, smooth_q;

  // Sequencer state
  logic [AW-1:0]  wp_q;
  logic [AW:0]    fill_q;
  logic [31:0]    wow_ph_q, flut_ph_q;
  logic signed [23:0] lp_l_q, lp_r_q;

  // Per item registers
  logic signed [23:0] in_l_q, in_r_q;
  logic signed [15:0] sin_w_q, sin_f_q;
  logic [11:0]        fdepth_q;
  logic signed [28:0] mod_w_q;
  logic signed [29:0] mod_q;
  logic [MAG_W-1:0]   mag_q;
  logic               neg_q;
  logic [SW-1:0]      step_q;
  logic [AW-1:0]      i0_q, i1_q;
  logic [22:0]        frac_q;
  logic               v0_q, v1_q;
  logic signed [23:0] a_l_q, a_r_q;
  logic signed [23:0] echo_l_q, echo_r_q;
  logic signed [42:0] lpp_l_q, lpp_r_q;
  logic signed [41:0] wetp_l_q, wetp_r_q;
  logic               out_valid_q;
  logic [47:0]        out_q;

  // Delay memory
  logic [47:0]   mem_q [DELAY_FRAMES];
  logic [47:0]   rd_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [47:0]   wdata;

  // Quarter-wave sine table
  logic [14:0] sine_rom [SQ + 1];
  for (genvar k = 0; k <= SQ; k++) begin : g_rom
    localparam longint unsigned X = (longint'(k) * ste_pkg::HalfPiQ30) / SQ;
    assign sine_rom[k] = ste_pkg::sine_q15(X);
  end

  // Shared sine lookup, wow in ST_WOW, flutter otherwise
  logic [31:0]        phase;
  logic [30+SQW-1:0]  idx_prod;
  logic [SQW-1:0]     idx, rom_addr;
  logic signed [15:0] sine_val;
  always_comb begin
    phase = (state_q == ST_WOW) ? wow_ph_q : flut_ph_q;
    idx_prod = {{SQW{1'b0}}, phase[29:0]} * (30 + SQW)'(SQ);
    idx = idx_prod[30 +: SQW];
    rom_addr = phase[30] ? SQW'(SQ) - idx : idx;
    sine_val = phase[31] ? -$signed({1'b0, sine_rom[rom_addr]})
                         : $signed({1'b0, sine_rom[rom_addr]});
  end

  // Read position pieces
  logic signed [MAG_W+1:0] v_pos;
  logic [MAG_W:0]          span_sh;
  logic [MAG_W:0]          pos_fix;
  always_comb begin
    v_pos = $signed({2'b00, MAG_W'(wp_q) << 23})
          - $signed({2'b00, MAG_W'(base_q) << 15})
          - (MAG_W + 2)'(mod_q);
    span_sh = SPAN << step_q;
    if (!neg_q || mag_q == '0) pos_fix = {1'b0, mag_q};
    else pos_fix = SPAN - {1'b0, mag_q};
  end

  // Arithmetic for the echo path
  logic signed [24:0] d_l, d_r;
  logic signed [48:0] ip_l, ip_r;
  logic signed [23:0] a_l, a_r, b_l, b_r;
  logic signed [24:0] e_l_diff, e_r_diff;
  logic signed [31:0] lp_l_new, lp_r_new, out_l_new, out_r_new;
  logic signed [40:0] fbp_l, fbp_r;
  logic signed [31:0] st_l, st_r;
  always_comb begin
    a_l = $signed(a_l_q);
    a_r = $signed(a_r_q);
    b_l = v1_q ? $signed(rd_q[23:0]) : 24'sd0;
    b_r = v1_q ? $signed(rd_q[47:24]) : 24'sd0;
    d_l = 25'(b_l) - 25'(a_l);
    d_r = 25'(b_r) - 25'(a_r);
    ip_l = 49'(d_l) * $signed({26'd0, frac_q});
    ip_r = 49'(d_r) * $signed({26'd0, frac_q});
    e_l_diff = 25'(echo_l_q) - 25'(lp_l_q);
    e_r_diff = 25'(echo_r_q) - 25'(lp_r_q);
    lp_l_new = 32'(lp_l_q) + 32'((lpp_l_q + 43'sd32768) >>> 16);
    lp_r_new = 32'(lp_r_q) + 32'((lpp_r_q + 43'sd32768) >>> 16);
    out_l_new = 32'(in_l_q) + 32'((wetp_l_q + 42'sd32768) >>> 16);
    out_r_new = 32'(in_r_q) + 32'((wetp_r_q + 42'sd32768) >>> 16);
    fbp_l = 41'(lp_l_q) * $signed({25'd0, fb_q});
    fbp_r = 41'(lp_r_q) * $signed({25'd0, fb_q});
    st_l = 32'(in_l_q) + 32'((fbp_l + 41'sd32768) >>> 16);
    st_r = 32'(in_r_q) + 32'((fbp_r + 41'sd32768) >>> 16);
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_q;

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_WOW;
      ST_WOW:  state_d = ST_FLUT;
      ST_FLUT: state_d = ST_MOD;
      ST_MOD:  state_d = ST_SUB;
      ST_SUB:  state_d = ST_RED;
      ST_RED:  if (step_q == '0) state_d = ST_FIX;
      ST_FIX:  state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_INT;
      ST_INT:  state_d = ST_LP1;
      ST_LP1:  state_d = ST_LP2;
      ST_LP2:  if (out_free) state_d = ST_FB;
      ST_FB:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory address and write; hold the second address so rd_q keeps it into ST_INT
  always_comb begin
    raddr = (state_q == ST_RD1 || state_q == ST_RD2) ? i1_q : i0_q;
    we = (state_q == ST_FB);
    wdata = {ste_pkg::sat24(st_r), ste_pkg::sat24(st_l)};
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wp_q] <= wdata;
    rd_q <= mem_q[raddr];
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      base_q <= ste_pkg::BaseDelayReset;
      depth_q <= ste_pkg::ModDepthReset;
      wow_step_q <= ste_pkg::WowStepReset;
      flut_step_q <= ste_pkg::FlutterStepReset;
      fb_q <= ste_pkg::FeedbackReset;
      wet_q <= ste_pkg::WetReset;
      smooth_q <= ste_pkg::SmoothReset;
      wp_q <= '0;
      fill_q <= '0;
      wow_ph_q <= '0;
      flut_ph_q <= '0;
      lp_l_q <= '0;
      lp_r_q <= '0;
      out_valid_q <= 1'b0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ste_pkg::CFG_BASE_DELAY:   base_q <= cfg_wdata_i[23:0];
          ste_pkg::CFG_MOD_DEPTH:    depth_q <= cfg_wdata_i[12:0];
          ste_pkg::CFG_WOW_STEP:     wow_step_q <= cfg_wdata_i[30:0];
          ste_pkg::CFG_FLUTTER_STEP: flut_step_q <= cfg_wdata_i[30:0];
          ste_pkg::CFG_FEEDBACK:     fb_q <= cfg_wdata_i[15:0];
          ste_pkg::CFG_WET:          wet_q <= cfg_wdata_i[16:0];
          ste_pkg::CFG_SMOOTH:       smooth_q <= cfg_wdata_i[16:0];
          default: ;
        endcase
      end
      // Raise the result at the lowpass update, drop it once taken
      if (state_q == ST_LP2 && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        ST_FLUT: begin
          wow_ph_q <= wow_ph_q + {1'b0, wow_step_q};
          flut_ph_q <= flut_ph_q + {1'b0, flut_step_q};
        end
        ST_SUB: step_q <= SW'(REDUCE_STEPS - 1);
        ST_RED: if (step_q != '0) step_q <= step_q - 1'b1;
        ST_LP2: begin
          if (out_free) begin
            lp_l_q <= ste_pkg::sat24(lp_l_new);
            lp_r_q <= ste_pkg::sat24(lp_r_new);
          end
        end
        ST_FB: begin
          wp_q <= (wp_q == AW'(DELAY_FRAMES - 1)) ? '0 : wp_q + 1'b1;
          if (fill_q != (AW + 1)'(DELAY_FRAMES)) fill_q <= fill_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        in_l_q <= $signed(s_axis_tdata[23:0]);
        in_r_q <= $signed(s_axis_tdata[47:24]);
      end
      ST_WOW: begin
        sin_w_q <= sine_val;
        fdepth_q <= 12'(({15'd0, depth_q} * {13'd0, ste_pkg::FlutterRatio} + 28'd32768) >> 16);
      end
      ST_FLUT: begin
        sin_f_q <= sine_val;
        mod_w_q <= 29'(sin_w_q) * $signed({16'd0, depth_q});
      end
      ST_MOD: mod_q <= 30'(mod_w_q) + 30'(sin_f_q) * $signed({18'd0, fdepth_q});
      ST_SUB: begin
        neg_q <= v_pos[MAG_W+1];
        mag_q <= v_pos[MAG_W+1] ? MAG_W'(-v_pos) : MAG_W'(v_pos);
      end
      ST_RED: if ({1'b0, mag_q} >= span_sh) mag_q <= MAG_W'({1'b0, mag_q} - span_sh);
      ST_FIX: begin
        i0_q <= pos_fix[23 +: AW];
        i1_q <= (pos_fix[23 +: AW] == AW'(DELAY_FRAMES - 1)) ? '0 : pos_fix[23 +: AW] + 1'b1;
        frac_q <= pos_fix[22:0];
      end
      ST_RD0: v0_q <= (fill_q > {1'b0, i0_q});
      ST_RD1: begin
        v1_q <= (fill_q > {1'b0, i1_q});
        a_l_q <= v0_q ? $signed(rd_q[23:0]) : 24'sd0;
        a_r_q <= v0_q ? $signed(rd_q[47:24]) : 24'sd0;
      end
      ST_INT: begin
        echo_l_q <= a_l + 24'((ip_l + 49'sd4194304) >>> 23);
        echo_r_q <= a_r + 24'((ip_r + 49'sd4194304) >>> 23);
      end
      ST_LP1: begin
        lpp_l_q <= 43'(e_l_diff) * $signed({26'd0, smooth_q});
        lpp_r_q <= 43'(e_r_diff) * $signed({26'd0, smooth_q});
        wetp_l_q <= 42'(echo_l_q) * $signed({25'd0, wet_q});
        wetp_r_q <= 42'(echo_r_q) * $signed({25'd0, wet_q});
      end
      ST_LP2: if (out_free) out_q <= {ste_pkg::sat24(out_r_new), ste_pkg::sat24(out_l_new)};
      default: ;
    endcase
  end

  // ST_RD2 and ST_INT see the second read in rd_q; nothing latched in ST_RD2
endmodule

/* tb/ste_checker.sv */
// Checker for the stereo tape echo: watches the channels, predicts each frame, compares.
module ste_checker (
  input  logic        clk_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // in_left, in_right
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // out_left, out_right
  input  logic        cfg_we_i,
  input  logic [ste_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ste_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LineFrames = 65536;
  localparam int QuarterLen = 256;
  localparam longint LineSpan = longint'(LineFrames) << 23;

  typedef struct packed {
    logic signed [23:0] right;
    logic signed [23:0] left;
  } frame_t;

  // Register copies
  logic [23:0] delay_cfg;
  logic [12:0] wow_depth;
  logic [30:0] wow_step;
  logic [30:0] flutter_step;
  logic [15:0] feedback;
  logic [16:0] wet;
  logic [16:0] smooth;

  // Echo state
  int          quarter_sine [0:QuarterLen];
  int          tape_left [LineFrames];
  int          tape_right [LineFrames];
  logic [15:0] wr_frame;
  logic [31:0] wow_phase;
  logic [31:0] flutter_phase;
  int          lowpass_left;
  int          lowpass_right;

  frame_t      expected_frames [$];
  int          mismatches;

  // Sine of quarter-wave entry k in Q15, Taylor series in Q30
  function automatic int sine_entry(int k);
    longint unsigned x, x2, t, s;
    x  = (longint'(k) * 64'd1686629713) / QuarterLen;
    x2 = (x * x) >> 30;
    t  = (64'd1 << 30) - x2 / 110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return int'(s);
  endfunction

  function automatic int osc_sine(logic [31:0] ph);
    int idx;
    int v;
    idx = int'(ph[29:22]);
    v = ph[30] ? quarter_sine[QuarterLen - idx] : quarter_sine[idx];
    return ph[31] ? -v : v;
  endfunction

  // Round half up, then shift (arithmetic shift floors)
  function automatic longint round_down(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic int clip24(longint v);
    if (v > 64'sd8388607) return 8388607;
    if (v < -64'sd8388608) return -8388608;
    return int'(v);
  endfunction

  // Advance the echo by one frame and return the output frame
  function automatic frame_t echo_frame(frame_t din);
    longint flut_depth, modu, pos, frac;
    int     i0, i1, echo_l, echo_r, in_l, in_r;
    frame_t r;
    in_l = int'(din.left);
    in_r = int'(din.right);
    flut_depth = (longint'(wow_depth) * 22938 + 32768) >>> 16;
    modu = longint'(osc_sine(wow_phase)) * longint'(wow_depth)
         + longint'(osc_sine(flutter_phase)) * flut_depth;
    wow_phase     = wow_phase + {1'b0, wow_step};
    flutter_phase = flutter_phase + {1'b0, flutter_step};
    pos = (longint'(wr_frame) <<< 23) - (longint'(delay_cfg) <<< 15) - modu;
    pos = pos % LineSpan;
    if (pos < 0) pos = pos + LineSpan;
    i0 = int'(pos >>> 23);
    i1 = (i0 + 1) % LineFrames;
    frac = pos & ((64'sd1 <<< 23) - 1);
    echo_l = tape_left[i0] + int'(round_down(
             (longint'(tape_left[i1]) - tape_left[i0]) * frac, 23));
    echo_r = tape_right[i0] + int'(round_down(
             (longint'(tape_right[i1]) - tape_right[i0]) * frac, 23));
    lowpass_left = clip24(lowpass_left + round_down(
                   (longint'(echo_l) - lowpass_left) * longint'(smooth), 16));
    lowpass_right = clip24(lowpass_right + round_down(
                    (longint'(echo_r) - lowpass_right) * longint'(smooth), 16));
    tape_left[wr_frame] = clip24(in_l + round_down(
                          longint'(lowpass_left) * longint'(feedback), 16));
    tape_right[wr_frame] = clip24(in_r + round_down(
                           longint'(lowpass_right) * longint'(feedback), 16));
    r.left  = 24'(clip24(in_l + round_down(longint'(echo_l) * longint'(wet), 16)));
    r.right = 24'(clip24(in_r + round_down(longint'(echo_r) * longint'(wet), 16)));
    wr_frame = wr_frame + 16'd1;
    return r;
  endfunction

  // Reset state
  initial begin
    for (int k = 0; k <= QuarterLen; k++) quarter_sine[k] = sine_entry(k);
    for (int k = 0; k < LineFrames; k++) begin
      tape_left[k] = 0;
      tape_right[k] = 0;
    end
    wr_frame = '0;
    wow_phase = '0;
    flutter_phase = '0;
    lowpass_left = 0;
    lowpass_right = 0;
    delay_cfg = ste_pkg::BaseDelayReset;
    wow_depth = ste_pkg::ModDepthReset;
    wow_step = ste_pkg::WowStepReset;
    flutter_step = ste_pkg::FlutterStepReset;
    feedback = ste_pkg::FeedbackReset;
    wet = ste_pkg::WetReset;
    smooth = ste_pkg::SmoothReset;
    mismatches = 0;
    checked_o = 0;
    pending_o = 0;
  end

  assign fail_count_o = mismatches;

  // Sample at the falling edge; handshakes complete at the next rising edge
  always @(negedge clk_i) begin
    frame_t got, want;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ste_pkg::CFG_BASE_DELAY:   delay_cfg = cfg_wdata_i[23:0];
        ste_pkg::CFG_MOD_DEPTH:    wow_depth = cfg_wdata_i[12:0];
        ste_pkg::CFG_WOW_STEP:     wow_step = cfg_wdata_i[30:0];
        ste_pkg::CFG_FLUTTER_STEP: flutter_step = cfg_wdata_i[30:0];
        ste_pkg::CFG_FEEDBACK:     feedback = cfg_wdata_i[15:0];
        ste_pkg::CFG_WET:          wet = cfg_wdata_i[16:0];
        ste_pkg::CFG_SMOOTH:       smooth = cfg_wdata_i[16:0];
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready)
      expected_frames.push_back(echo_frame(frame_t'(s_axis_tdata)));
    if (m_axis_tvalid && m_axis_tready) begin
      got = frame_t'(m_axis_tdata);
      checked_o++;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output frame L=%0d R=%0d", got.left, got.right);
      end else begin
        want = expected_frames.pop_front();
        if (got.left !== want.left || got.right !== want.right) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: frame %0d expected L=%0d R=%0d, got L=%0d R=%0d",
                     checked_o, want.left, want.right, got.left, got.right);
        end
      end
    end
    pending_o = expected_frames.size();
  end

endmodule

/* tb/tb_top.sv */
// Top of the stereo tape echo testbench: stimulus, flow control and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ste_pkg::CfgIdxW-1:0] CfgUnknown = 3'd7;
  localparam int CycleLimit = 600000;
  localparam int LongHold = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // in_left, in_right
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // out_left, out_right
  logic        cfg_we_i;
  logic [ste_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [ste_pkg::CfgDataW-1:0] cfg_wdata_i;

  int fail_count, pending, checked;
  int sent;
  int cycles;
  int stall_pct;
  int gap_max;
  int burst_left;
  bit hold_req;

  stereo_tape_echo uut (.*);

  ste_checker checker_i (
    .clk_i, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output side: random stalls, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic write_reg(logic [ste_pkg::CfgIdxW-1:0] idx,
                           logic [ste_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one frame, in bursts with random gaps
  task automatic send_frame(logic [23:0] left, logic [23:0] right);
    bit ok;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {right, left};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    sent++;
  endtask

  task automatic drain();
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      1: return 24'($signed($urandom_range(0, 8191)) - 4096);
      default: return 24'($urandom);
    endcase
  endfunction

  // Random register setting; short delays so echoes and feedback show up
  task automatic random_setting();
    write_reg(ste_pkg::CFG_BASE_DELAY, ($urandom_range(0, 7) == 0) ?
              31'($urandom_range(256, 16776704)) : 31'($urandom_range(256, 256 * 120)));
    write_reg(ste_pkg::CFG_MOD_DEPTH, 31'($urandom_range(0, 8191)));
    write_reg(ste_pkg::CFG_WOW_STEP, 31'($urandom));
    write_reg(ste_pkg::CFG_FLUTTER_STEP, 31'($urandom));
    write_reg(ste_pkg::CFG_FEEDBACK, 31'($urandom_range(0, 65535)));
    write_reg(ste_pkg::CFG_WET, 31'($urandom_range(0, 131071)));
    write_reg(ste_pkg::CFG_SMOOTH, 31'($urandom_range(0, 131071)));
    end_writes();
  endtask

  initial begin
    logic [23:0] edge_vals [6];
    edge_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h555555, 24'hAAAAAA};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    cycles = 0;
    sent = 0;
    stall_pct = 20;
    gap_max = 4;
    burst_left = 0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings, sample extremes
    for (int i = 0; i < 6; i++) send_frame(edge_vals[i], edge_vals[5 - i]);
    drain();

    // Shortest delay, fastest oscillators, top of the wet and smoothing ranges, unknown index
    write_reg(ste_pkg::CFG_BASE_DELAY, 31'd256);
    write_reg(ste_pkg::CFG_MOD_DEPTH, 31'd4608);
    write_reg(ste_pkg::CFG_WOW_STEP, 31'h7FFFFFFF);
    write_reg(ste_pkg::CFG_FLUTTER_STEP, 31'h7FFFFFFF);
    write_reg(ste_pkg::CFG_FEEDBACK, 31'd60293);
    write_reg(ste_pkg::CFG_WET, 31'd65536);
    write_reg(ste_pkg::CFG_SMOOTH, 31'd65536);
    write_reg(CfgUnknown, 31'h7FFFFFFF);
    end_writes();
    for (int i = 0; i < 10; i++) send_frame(edge_vals[i % 2], edge_vals[(i + 1) % 2]);
    drain();

    // Longest delay wraps the read point; gains beyond their ranges saturate
    write_reg(ste_pkg::CFG_BASE_DELAY, 31'd16776704);
    write_reg(ste_pkg::CFG_MOD_DEPTH, 31'd0);
    write_reg(ste_pkg::CFG_WOW_STEP, 31'd0);
    write_reg(ste_pkg::CFG_FLUTTER_STEP, 31'd0);
    write_reg(ste_pkg::CFG_FEEDBACK, 31'd65535);
    write_reg(ste_pkg::CFG_WET, 31'd131071);
    write_reg(ste_pkg::CFG_SMOOTH, 31'd131071);
    end_writes();
    for (int i = 0; i < 8; i++) send_frame(edge_vals[i % 6], edge_vals[(i + 2) % 6]);
    drain();

    // Random phases with varied flow control
    for (int ph = 0; ph < 8; ph++) begin
      random_setting();
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 70);
      gap_max = (ph % 4 == 1) ? 0 : $urandom_range(1, 12);
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < 100; i++) send_frame(rand_sample(), rand_sample());
      drain();
    end

    $display("Sent %0d frames over 11 register settings, %0d output frames compared.",
             sent, checked);
    $display("Covered sample extremes, delay wrap, gain saturation and a long output stall.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
